// ===== src/adbmd_pkg.sv =====
// ----------------------------------------------------------------------------
// adbmd_pkg: shared types and constants of the message deframer
// Command words, status and class codes, the queued item format and the
// helpers that classify a command and decide whether it is accepted.
// ----------------------------------------------------------------------------
package adbmd_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PaySizeW   = 17;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic [WordW-1:0] CmdSync = 32'h434E5953;
  localparam logic [WordW-1:0] CmdCnxn = 32'h4E584E43;
  localparam logic [WordW-1:0] CmdOpen = 32'h4E45504F;
  localparam logic [WordW-1:0] CmdOkay = 32'h59414B4F;
  localparam logic [WordW-1:0] CmdClse = 32'h45534C43;
  localparam logic [WordW-1:0] CmdWrte = 32'h45545257;
  localparam logic [WordW-1:0] CmdAuth = 32'h48545541;

  localparam logic [WordW-1:0]    VersionReset = 32'h01000000;
  localparam logic [PaySizeW-1:0] PaySizeReset = 17'd4096;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_MAGIC = 3'd1,
    ST_CHECK = 3'd2,
    ST_LEN   = 3'd3,
    ST_SIZE  = 3'd4,
    ST_UNEXP = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CLS_SYNC    = 3'd0,
    CLS_CNXN    = 3'd1,
    CLS_OPEN    = 3'd2,
    CLS_OKAY    = 3'd3,
    CLS_CLSE    = 3'd4,
    CLS_WRTE    = 3'd5,
    CLS_AUTH    = 3'd6,
    CLS_UNKNOWN = 3'd7
  } cmd_class_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERSION  = 1'b0,
    CFG_PAY_SIZE = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    PH_WAIT_HDR = 1'b0,
    PH_RECV_PAY = 1'b1
  } phase_e;

  typedef struct packed {
    logic [WordW-1:0]    version;
    logic [PaySizeW-1:0] pay_size;
  } cfg_t;

  // One classified input item as it sits in the queue.
  typedef struct packed {
    logic             op;
    logic [WordW-1:0] cmd;
    logic [WordW-1:0] a0;
    logic [WordW-1:0] a1;
    logic [WordW-1:0] len;
    logic [WordW-1:0] chk;
    logic [ByteW-1:0] pbyte;
    logic             last;
    logic             magic_ok;
    logic             oversize;
    logic             len_zero;
    cmd_class_e       cls;
  } item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    status_e          status;
    cmd_class_e       cls;
    logic [WordW-1:0] cmd;
    logic [WordW-1:0] a0;
    logic [WordW-1:0] a1;
    logic [WordW-1:0] len;
    logic             accepted;
  } result_t;

  function automatic cmd_class_e classify(input logic [WordW-1:0] cmd);
    cmd_class_e cls;
    case (cmd)
      CmdSync: cls = CLS_SYNC;
      CmdCnxn: cls = CLS_CNXN;
      CmdOpen: cls = CLS_OPEN;
      CmdOkay: cls = CLS_OKAY;
      CmdClse: cls = CLS_CLSE;
      CmdWrte: cls = CLS_WRTE;
      CmdAuth: cls = CLS_AUTH;
      default: cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

  function automatic logic acceptance(input cmd_class_e cls, input logic cnxn_match,
                                      input logic len_nonzero);
    logic acc;
    case (cls)
      CLS_CNXN:                     acc = cnxn_match;
      CLS_OPEN:                     acc = len_nonzero;
      CLS_OKAY, CLS_CLSE, CLS_WRTE: acc = 1'b1;
      default:                      acc = 1'b0;
    endcase
    return acc;
  endfunction

endpackage

// ===== src/adbmd_front.sv =====
// ----------------------------------------------------------------------------
// adbmd_front: input stage of the message deframer
// Takes input items, checks the magic word and the length limit of a header,
// classifies the command and hands the result to the queue.
// ----------------------------------------------------------------------------
module adbmd_front #(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [adbmd_pkg::WordW-1:0]   hdr_command_i,
  input  logic [adbmd_pkg::WordW-1:0]   hdr_first_arg_i,
  input  logic [adbmd_pkg::WordW-1:0]   hdr_second_arg_i,
  input  logic [adbmd_pkg::WordW-1:0]   hdr_length_i,
  input  logic [adbmd_pkg::WordW-1:0]   hdr_check_i,
  input  logic [adbmd_pkg::WordW-1:0]   hdr_magic_i,
  input  logic [adbmd_pkg::ByteW-1:0]   payload_byte_i,
  input  logic                          payload_last_i,
  input  adbmd_pkg::qstat_t             qstat_i,
  output logic                          push_o,
  output adbmd_pkg::item_t              item_o
);

  localparam logic [adbmd_pkg::WordW-1:0] MaxLen = adbmd_pkg::WordW'(MAX_PAYLOAD);

  logic             valid_q, valid_d;
  adbmd_pkg::item_t item_q, item_d;
  logic             in_take;

  always_comb begin
    item_d.op       = operation_i;
    item_d.cmd      = hdr_command_i;
    item_d.a0       = hdr_first_arg_i;
    item_d.a1       = hdr_second_arg_i;
    item_d.len      = hdr_length_i;
    item_d.chk      = hdr_check_i;
    item_d.pbyte    = payload_byte_i;
    item_d.last     = payload_last_i;
    item_d.magic_ok = (hdr_magic_i == ~hdr_command_i);
    item_d.oversize = (hdr_length_i > MaxLen);
    item_d.len_zero = (hdr_length_i == '0);
    item_d.cls      = adbmd_pkg::classify(hdr_command_i);
  end

  // The held item moves on whenever the queue has room, so a new one can
  // be taken in the same cycle.
  assign push_o     = valid_q && !qstat_i.full;
  assign in_stall_o = valid_q && qstat_i.full;
  assign in_take    = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_take) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== src/adbmd_queue.sv =====
// ----------------------------------------------------------------------------
// adbmd_queue: short queue between front and back
// A small first-in first-out store of classified items that lets each side
// stall on its own.
// ----------------------------------------------------------------------------
module adbmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  adbmd_pkg::item_t  item_i,
  input  logic              pop_i,
  output adbmd_pkg::qstat_t qstat_o,
  output adbmd_pkg::item_t  item_o
);

  adbmd_pkg::item_t                 mem_q [adbmd_pkg::QueueDepth];
  logic [adbmd_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [adbmd_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [adbmd_pkg::QPtrW:0]        count_q, count_d;
  logic                             do_push, do_pop;

  assign qstat_o.not_empty = (count_q != '0);
  assign qstat_o.full      = (count_q == (adbmd_pkg::QPtrW + 1)'(adbmd_pkg::QueueDepth));
  assign do_push           = push_i && !qstat_o.full;
  assign do_pop            = pop_i && qstat_o.not_empty;
  assign item_o            = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== src/adbmd_back.sv =====
// ----------------------------------------------------------------------------
// adbmd_back: message state machine of the deframer
// Holds a good header, sums and counts its payload bytes, and builds one
// report per finished or failed message into the output register.
// ----------------------------------------------------------------------------
module adbmd_back #(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  adbmd_pkg::cfg_t             cfg_i,
  input  adbmd_pkg::qstat_t           qstat_i,
  input  adbmd_pkg::item_t            item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output adbmd_pkg::result_t          res_o
);

  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned SumW = $clog2(MAX_PAYLOAD * 255 + 1);

  adbmd_pkg::phase_e                phase_q, phase_d;
  logic [adbmd_pkg::WordW-1:0]      held_cmd_q, held_a0_q, held_a1_q, held_chk_q;
  logic [LenW-1:0]                  held_len_q;
  adbmd_pkg::cmd_class_e            held_cls_q;
  logic [SumW-1:0]                  sum_q, sum_n;
  logic [LenW-1:0]                  cnt_q, cnt_n;
  logic                             cnt_short;
  logic                             take;
  logic                             load_hdr;
  logic                             res_valid;
  adbmd_pkg::result_t               res;
  logic                             out_valid_q;
  adbmd_pkg::result_t               res_q;
  adbmd_pkg::status_e               rep_status;
  adbmd_pkg::cmd_class_e            rep_cls;
  logic [adbmd_pkg::WordW-1:0]      rep_cmd, rep_a0, rep_a1, rep_len;
  logic                             cnxn_match;

  // An item is taken whenever the output register is free or being emptied.
  assign take  = qstat_i.not_empty && (!out_valid_q || !out_stall_i);
  assign pop_o = take;

  assign sum_n     = sum_q + SumW'(item_i.pbyte);
  assign cnt_n     = cnt_q + 1'b1;
  assign cnt_short = (cnt_n < held_len_q);
  assign load_hdr  = (phase_q == adbmd_pkg::PH_WAIT_HDR) && !item_i.op &&
                     item_i.magic_ok && !item_i.oversize && !item_i.len_zero;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      adbmd_pkg::PH_WAIT_HDR: begin
        if (load_hdr) begin
          phase_d = adbmd_pkg::PH_RECV_PAY;
        end
      end
      adbmd_pkg::PH_RECV_PAY: begin
        if (!item_i.op || item_i.last || !cnt_short) begin
          phase_d = adbmd_pkg::PH_WAIT_HDR;
        end
      end
      default: phase_d = adbmd_pkg::PH_WAIT_HDR;
    endcase
  end

  // Report for the item at the head of the queue.
  always_comb begin
    res_valid  = 1'b0;
    rep_status = adbmd_pkg::ST_OK;
    rep_cls    = item_i.cls;
    rep_cmd    = item_i.cmd;
    rep_a0     = item_i.a0;
    rep_a1     = item_i.a1;
    rep_len    = item_i.len;
    case (phase_q)
      adbmd_pkg::PH_WAIT_HDR: begin
        if (item_i.op) begin
          res_valid  = 1'b1;
          rep_status = adbmd_pkg::ST_UNEXP;
          rep_cls    = adbmd_pkg::CLS_UNKNOWN;
          rep_cmd    = '0;
          rep_a0     = '0;
          rep_a1     = '0;
          rep_len    = '0;
        end else if (!item_i.magic_ok) begin
          res_valid  = 1'b1;
          rep_status = adbmd_pkg::ST_MAGIC;
        end else if (item_i.oversize) begin
          res_valid  = 1'b1;
          rep_status = adbmd_pkg::ST_SIZE;
        end else if (item_i.len_zero) begin
          res_valid  = 1'b1;
        end
      end
      adbmd_pkg::PH_RECV_PAY: begin
        rep_cls = held_cls_q;
        rep_cmd = held_cmd_q;
        rep_a0  = held_a0_q;
        rep_a1  = held_a1_q;
        rep_len = adbmd_pkg::WordW'(held_len_q);
        if (!item_i.op) begin
          res_valid  = 1'b1;
          rep_status = adbmd_pkg::ST_UNEXP;
        end else if (item_i.last || !cnt_short) begin
          res_valid = 1'b1;
          if ((cnt_n != held_len_q) || !item_i.last) begin
            rep_status = adbmd_pkg::ST_LEN;
          end else if (adbmd_pkg::WordW'(sum_n) != held_chk_q) begin
            rep_status = adbmd_pkg::ST_CHECK;
          end
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  assign cnxn_match = (rep_a0 == cfg_i.version) &&
                      (rep_a1 == adbmd_pkg::WordW'(cfg_i.pay_size));

  always_comb begin
    res.status   = rep_status;
    res.cls      = rep_cls;
    res.cmd      = rep_cmd;
    res.a0       = rep_a0;
    res.a1       = rep_a1;
    res.len      = rep_len;
    res.accepted = (rep_status == adbmd_pkg::ST_OK) &&
                   adbmd_pkg::acceptance(rep_cls, cnxn_match, rep_len != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= adbmd_pkg::PH_WAIT_HDR;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q     <= phase_d;
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      res_q <= res;
    end
    if (take && load_hdr) begin
      held_cmd_q <= item_i.cmd;
      held_a0_q  <= item_i.a0;
      held_a1_q  <= item_i.a1;
      held_len_q <= LenW'(item_i.len);
      held_chk_q <= item_i.chk;
      held_cls_q <= item_i.cls;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else if (take && (phase_q == adbmd_pkg::PH_RECV_PAY) && item_i.op) begin
      sum_q <= sum_n;
      cnt_q <= cnt_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/adb_message_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// adb_message_deframer_unit: receive-side message framing check
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------------
//   input   | in        | in_valid_i, in_stall_o | operation, header words, byte
//   result  | out       | out_valid_o, out_stall_i | status, class, words, accepted
//   config  | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One item per cycle is taken while in_stall_o is low; an item passes the
// input register, the queue and the output register before its report leaves.
// Reset clears the phase, the queue and all valid flags; the version and
// payload size registers return to their default values.
// A stalled result keeps the queue from draining; the input stalls only once
// the queue and the input register are both full.
// ----------------------------------------------------------------------------
module adb_message_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adbmd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [adbmd_pkg::WordW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [adbmd_pkg::WordW-1:0]         hdr_command_i,
  input  logic [adbmd_pkg::WordW-1:0]         hdr_first_arg_i,
  input  logic [adbmd_pkg::WordW-1:0]         hdr_second_arg_i,
  input  logic [adbmd_pkg::WordW-1:0]         hdr_length_i,
  input  logic [adbmd_pkg::WordW-1:0]         hdr_check_i,
  input  logic [adbmd_pkg::WordW-1:0]         hdr_magic_i,
  input  logic [adbmd_pkg::ByteW-1:0]         payload_byte_i,
  input  logic                                payload_last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic [2:0]                          command_class_o,
  output logic [adbmd_pkg::WordW-1:0]         command_word_o,
  output logic [adbmd_pkg::WordW-1:0]         first_arg_o,
  output logic [adbmd_pkg::WordW-1:0]         second_arg_o,
  output logic [adbmd_pkg::WordW-1:0]         payload_length_o,
  output logic                                accepted_o
);

  adbmd_pkg::cfg_t    cfg_q;
  adbmd_pkg::qstat_t  qstat;
  adbmd_pkg::item_t   front_item, head_item;
  adbmd_pkg::result_t res;
  logic               push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version  <= adbmd_pkg::VersionReset;
      cfg_q.pay_size <= adbmd_pkg::PaySizeReset;
    end else if (cfg_we_i) begin
      case (adbmd_pkg::cfg_idx_e'(cfg_index_i))
        adbmd_pkg::CFG_VERSION:  cfg_q.version  <= cfg_data_i;
        adbmd_pkg::CFG_PAY_SIZE: cfg_q.pay_size <= cfg_data_i[adbmd_pkg::PaySizeW-1:0];
        default: ;
      endcase
    end
  end

  adbmd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .hdr_command_i   (hdr_command_i),
    .hdr_first_arg_i (hdr_first_arg_i),
    .hdr_second_arg_i(hdr_second_arg_i),
    .hdr_length_i    (hdr_length_i),
    .hdr_check_i     (hdr_check_i),
    .hdr_magic_i     (hdr_magic_i),
    .payload_byte_i  (payload_byte_i),
    .payload_last_i  (payload_last_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .item_o          (front_item)
  );

  adbmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .qstat_o(qstat),
    .item_o (head_item)
  );

  adbmd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .item_i     (head_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign status_o         = res.status;
  assign command_class_o  = res.cls;
  assign command_word_o   = res.cmd;
  assign first_arg_o      = res.a0;
  assign second_arg_o     = res.a1;
  assign payload_length_o = res.len;
  assign accepted_o       = res.accepted;

endmodule

// ===== src/adbmd_checker.sv =====
// ----------------------------------------------------------------------------
// adbmd_checker: port-level checks of the message deframer
// Watches the result channel for reports that cannot be right.
// ----------------------------------------------------------------------------
module adbmd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [2:0]                    status_o,
  input logic [2:0]                    command_class_o,
  input logic [adbmd_pkg::WordW-1:0]   command_word_o,
  input logic [adbmd_pkg::WordW-1:0]   payload_length_o,
  input logic                          accepted_o
);

  // A stalled result transfer keeps its report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(command_word_o) && $stable(accepted_o))
    else $error("stalled result changed");

  // Only a clean report of a supported command can be accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |->
    status_o == adbmd_pkg::ST_OK &&
    (command_class_o == adbmd_pkg::CLS_CNXN || command_class_o == adbmd_pkg::CLS_OPEN ||
     command_class_o == adbmd_pkg::CLS_OKAY || command_class_o == adbmd_pkg::CLS_CLSE ||
     command_class_o == adbmd_pkg::CLS_WRTE))
    else $error("accepted report of wrong status or class");

  // An open message is accepted only when it carries a payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o && command_class_o == adbmd_pkg::CLS_OPEN |->
    payload_length_o != '0)
    else $error("empty open accepted");

  // The class must agree with the command word shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> command_class_o == adbmd_pkg::classify(command_word_o))
    else $error("class does not match command word");

endmodule

bind adb_message_deframer_unit adbmd_checker u_adbmd_checker (.*);
